// ===== hdl/uidg_pkg.sv =====
// shared widths, status codes and helpers for the unique id generator
package uidg_pkg;

    // fixed field widths of the block's ports
    localparam int IN_W   = 43;
    localparam int CFG_W  = 10;
    localparam int ID_W   = 63;
    localparam int CNT_W  = 32;
    localparam int STEP_W = 41;

    // result status codes
    localparam logic [1:0] ST_ISSUED  = 2'd0;
    localparam logic [1:0] ST_RETRY   = 2'd1;
    localparam logic [1:0] ST_NO_NODE = 2'd2;
    localparam logic [1:0] ST_RANGE   = 2'd3;

    // cap for the tracked backward step
    localparam logic [STEP_W-1:0] STEP_MAX = '1;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        return (&v) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== hdl/unique_id_generator_top.sv =====
// top level of the snowflake style unique id generator
//
// each request item carries the current milliseconds since the epoch and
// yields exactly one result item: a 63 bit id (ms, node, sequence packed
// from high to low), a status (issued, sequence exhausted so retry, node
// not set, time out of range) and the saturating health counters as they
// stand after that request. the block takes one item per clock and gives
// one result per clock while results are popped and full stays low; each
// item is held in the front queue and then in the back end's result queue.
// the rate is set by the back end's update of last millisecond and
// sequence, a compare, a subtract and an increment done once per cycle.
// the node number is written through the cfg channel, which is always
// ready; write it while no request is in flight. a node of zero makes every
// request report not initialized, and a new node applies to later ids
// without clearing any state.
module unique_id_generator_top import uidg_pkg::*; #(
    parameter int TIME_BITS = 41,
    parameter int SEQ_BITS  = 12,
    parameter int NODE_BITS = 10
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request side
    input  logic              push,
    output logic              full,
    input  logic [IN_W-1:0]   i_elapsed_ms,
    // result side
    output logic              empty,
    input  logic              pop,
    output logic [ID_W-1:0]   o_id_value,
    output logic [1:0]        o_status,
    output logic [CNT_W-1:0]  o_rollback_total,
    output logic [STEP_W-1:0] o_largest_rollback,
    output logic [CNT_W-1:0]  o_exhausted_total,
    // node number write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [CFG_W-1:0]  i_cfg_node_number
);

    // node number register, 0 means not initialized
    logic [CFG_W-1:0]     r_node_number, n_node_number;

    // front to back queue head
    logic                 q_valid;
    logic                 q_ready;
    logic [1:0]           q_status;
    logic [TIME_BITS-1:0] q_ms;
    logic [NODE_BITS-1:0] q_node;

    assign o_cfg_ready   = 1'b1;
    assign n_node_number = (i_cfg_valid && o_cfg_ready) ? i_cfg_node_number
                                                        : r_node_number;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_number <= '0;
        end else begin
            r_node_number <= n_node_number;
        end
    end

    // front: classify each request item and queue it
    uidg_front #(
        .TIME_BITS (TIME_BITS),
        .NODE_BITS (NODE_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .push          (push),
        .full          (full),
        .i_elapsed_ms  (i_elapsed_ms),
        .i_node_number (r_node_number),
        .o_q_valid     (q_valid),
        .i_q_ready     (q_ready),
        .o_q_status    (q_status),
        .o_q_ms        (q_ms),
        .o_q_node      (q_node)
    );

    // back: update sequence state, build ids, hold results
    uidg_back #(
        .TIME_BITS (TIME_BITS),
        .SEQ_BITS  (SEQ_BITS),
        .NODE_BITS (NODE_BITS)
    ) u_back (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_q_valid          (q_valid),
        .o_q_ready          (q_ready),
        .i_q_status         (q_status),
        .i_q_ms             (q_ms),
        .i_q_node           (q_node),
        .pop                (pop),
        .empty              (empty),
        .o_id_value         (o_id_value),
        .o_status           (o_status),
        .o_rollback_total   (o_rollback_total),
        .o_largest_rollback (o_largest_rollback),
        .o_exhausted_total  (o_exhausted_total)
    );

    // an item that was not issued carries no id
    a_no_id_unless_issued: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!empty && o_status != ST_ISSUED) |-> (o_id_value == '0))
        else $error("id present on a result that was not issued");

    // rollback count never drops from one result item to the next
    a_rollback_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(pop && !empty) && !empty)
            |-> (o_rollback_total >= $past(o_rollback_total)))
        else $error("rollback count went down");

    // largest backward step never shrinks between result items
    a_backstep_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(pop && !empty) && !empty)
            |-> (o_largest_rollback >= $past(o_largest_rollback)))
        else $error("largest rollback went down");

    // exhaustion count never drops between result items
    a_exhaust_monotonic: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_rst_n) && $past(pop && !empty) && !empty)
            |-> (o_exhausted_total >= $past(o_exhausted_total)))
        else $error("exhaustion count went down");

endmodule

// ===== hdl/uidg_fifo.sv =====
// small first-in first-out queue of flat words
module uidg_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;
    logic             wr_en;
    logic             rd_en;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign wr_en   = i_push & ~o_full;
    assign rd_en   = i_pop & ~o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (wr_en) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + PTR_W'(1);
        end
        if (rd_en) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + PTR_W'(1);
        end
        if (wr_en && !rd_en) begin
            n_count = r_count + CNT_W'(1);
        end else if (rd_en && !wr_en) begin
            n_count = r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

// ===== hdl/uidg_front.sv =====
// front end: accepts requests, checks node and time range, queues them
module uidg_front import uidg_pkg::*; #(
    parameter int TIME_BITS = 41,
    parameter int NODE_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 push,
    output logic                 full,
    input  logic [IN_W-1:0]      i_elapsed_ms,
    input  logic [CFG_W-1:0]     i_node_number,
    output logic                 o_q_valid,
    input  logic                 i_q_ready,
    output logic [1:0]           o_q_status,
    output logic [TIME_BITS-1:0] o_q_ms,
    output logic [NODE_BITS-1:0] o_q_node
);
    localparam int RAW_W = (TIME_BITS + 1 > IN_W) ? TIME_BITS + 1 : IN_W;
    localparam int Q_W   = 2 + TIME_BITS + NODE_BITS;

    logic [RAW_W-1:0]     raw_ext;
    logic [RAW_W-1:0]     ms_limit;
    logic [NODE_BITS-1:0] node;
    logic [1:0]           cls;
    logic [Q_W-1:0]       q_wdata;
    logic [Q_W-1:0]       q_rdata;
    logic                 q_empty;

    assign raw_ext  = RAW_W'(i_elapsed_ms);
    assign ms_limit = RAW_W'(1) << TIME_BITS;
    assign node     = NODE_BITS'(i_node_number);

    // node check comes before the time range check
    always_comb begin
        priority if (node == '0) begin
            cls = ST_NO_NODE;
        end else if (i_elapsed_ms[IN_W-1] || (raw_ext >= ms_limit)) begin
            cls = ST_RANGE;
        end else begin
            cls = ST_ISSUED;
        end
    end

    assign q_wdata = {cls, TIME_BITS'(raw_ext), node};

    uidg_fifo #(
        .WIDTH (Q_W),
        .DEPTH (2)
    ) u_cls_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (q_wdata),
        .o_full  (full),
        .i_pop   (i_q_ready),
        .o_data  (q_rdata),
        .o_empty (q_empty)
    );

    assign o_q_valid                      = ~q_empty;
    assign {o_q_status, o_q_ms, o_q_node} = q_rdata;

endmodule

// ===== hdl/uidg_back.sv =====
// back end: sequence and clock tracking state, id assembly, result queue
module uidg_back import uidg_pkg::*; #(
    parameter int TIME_BITS = 41,
    parameter int SEQ_BITS  = 12,
    parameter int NODE_BITS = 10
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_q_valid,
    output logic                 o_q_ready,
    input  logic [1:0]           i_q_status,
    input  logic [TIME_BITS-1:0] i_q_ms,
    input  logic [NODE_BITS-1:0] i_q_node,
    input  logic                 pop,
    output logic                 empty,
    output logic [ID_W-1:0]      o_id_value,
    output logic [1:0]           o_status,
    output logic [CNT_W-1:0]     o_rollback_total,
    output logic [STEP_W-1:0]    o_largest_rollback,
    output logic [CNT_W-1:0]     o_exhausted_total
);
    localparam int EXT_W  = (TIME_BITS > STEP_W) ? TIME_BITS : STEP_W;
    localparam int PACK_W = TIME_BITS + NODE_BITS + SEQ_BITS;
    localparam int RES_W  = ID_W + 2 + CNT_W + STEP_W + CNT_W;

    logic [TIME_BITS-1:0] r_last_millis, n_last_millis;
    logic [SEQ_BITS-1:0]  r_last_seq, n_last_seq;
    logic [CNT_W-1:0]     r_rollback, n_rollback;
    logic [STEP_W-1:0]    r_max_step, n_max_step;
    logic [CNT_W-1:0]     r_exhaust, n_exhaust;

    logic                 take;
    logic                 is_ok;
    logic                 went_back;
    logic                 not_ahead;
    logic [TIME_BITS-1:0] step_diff;
    logic [EXT_W-1:0]     step_ext;
    logic [STEP_W-1:0]    step_cap;
    logic [SEQ_BITS:0]    seq_inc;
    logic                 exhausted;
    logic [TIME_BITS-1:0] new_ms;
    logic [SEQ_BITS-1:0]  new_seq;
    logic [PACK_W-1:0]    id_pack;
    logic [1:0]           res_status;
    logic [ID_W-1:0]      res_id;
    logic [RES_W-1:0]     res_wdata;
    logic [RES_W-1:0]     res_rdata;
    logic                 res_full;

    assign take  = i_q_valid & ~res_full;
    assign o_q_ready = ~res_full;
    assign is_ok = (i_q_status == ST_ISSUED);

    assign went_back = (i_q_ms < r_last_millis);
    assign not_ahead = went_back | (i_q_ms == r_last_millis);
    assign step_diff = r_last_millis - i_q_ms;
    assign step_ext  = EXT_W'(step_diff);
    assign step_cap  = (step_ext > EXT_W'(STEP_MAX)) ? STEP_MAX : STEP_W'(step_ext);

    assign seq_inc   = {1'b0, r_last_seq} + (SEQ_BITS + 1)'(1);
    assign exhausted = not_ahead & seq_inc[SEQ_BITS];
    assign new_ms    = not_ahead ? r_last_millis : i_q_ms;
    assign new_seq   = not_ahead ? seq_inc[SEQ_BITS-1:0] : '0;
    assign id_pack   = {new_ms, i_q_node, new_seq};

    always_comb begin
        n_last_millis = r_last_millis;
        n_last_seq    = r_last_seq;
        n_rollback    = r_rollback;
        n_max_step    = r_max_step;
        n_exhaust     = r_exhaust;
        if (take && is_ok) begin
            if (went_back) begin
                n_rollback = sat_inc(r_rollback);
                if (step_cap > r_max_step) begin
                    n_max_step = step_cap;
                end
            end
            if (exhausted) begin
                n_exhaust = sat_inc(r_exhaust);
            end else begin
                n_last_millis = new_ms;
                n_last_seq    = new_seq;
            end
        end
    end

    always_comb begin
        priority if (!is_ok) begin
            res_status = i_q_status;
        end else if (exhausted) begin
            res_status = ST_RETRY;
        end else begin
            res_status = ST_ISSUED;
        end
    end

    assign res_id    = (res_status == ST_ISSUED) ? ID_W'(id_pack) : '0;
    assign res_wdata = {res_id, res_status, n_rollback, n_max_step, n_exhaust};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_millis <= '0;
            r_last_seq    <= '0;
            r_rollback    <= '0;
            r_max_step    <= '0;
            r_exhaust     <= '0;
        end else begin
            r_last_millis <= n_last_millis;
            r_last_seq    <= n_last_seq;
            r_rollback    <= n_rollback;
            r_max_step    <= n_max_step;
            r_exhaust     <= n_exhaust;
        end
    end

    uidg_fifo #(
        .WIDTH (RES_W),
        .DEPTH (2)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (take),
        .i_data  (res_wdata),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_data  (res_rdata),
        .o_empty (empty)
    );

    assign {o_id_value, o_status, o_rollback_total, o_largest_rollback,
            o_exhausted_total} = res_rdata;

endmodule
